### rtl/core/smwe_pkg.sv
// Shared types, codes and sizes for the stack machine word executor.
`timescale 1ns / 1ps

package smwe_pkg;

	localparam int unsigned STACK_DEPTH = 32;
	localparam int unsigned WORD_WIDTH  = 32;
	localparam int unsigned MAX_OUT     = 32;
	localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
	localparam int unsigned DIV_CW      = $clog2(WORD_WIDTH);

	// word kinds
	localparam logic [3:0] KIND_PUSH  = 4'd0;
	localparam logic [3:0] KIND_ADD   = 4'd1;
	localparam logic [3:0] KIND_SUB   = 4'd2;
	localparam logic [3:0] KIND_MUL   = 4'd3;
	localparam logic [3:0] KIND_DIV   = 4'd4;
	localparam logic [3:0] KIND_EQ    = 4'd5;
	localparam logic [3:0] KIND_POP   = 4'd6;
	localparam logic [3:0] KIND_DUMP  = 4'd7;
	localparam logic [3:0] KIND_BEGIN = 4'd8;
	localparam logic [3:0] KIND_END   = 4'd9;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_UNF  = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;
	localparam logic [1:0] ST_DIVZ = 2'd3;

	// source of an emitted value
	localparam logic [1:0] EMIT_NONE = 2'd0;
	localparam logic [1:0] EMIT_TOP  = 2'd1;
	localparam logic [1:0] EMIT_DUMP = 2'd2;

	typedef logic [WORD_WIDTH-1:0] word_t;

	typedef struct packed {
		logic [3:0]         kind;
		logic signed [31:0] literal;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               has_value;
		logic               last;
		logic [1:0]         status;
		logic [5:0]         depth;
		logic               compiling;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;
		logic       rd_top;
		logic       rd_second;
		logic       lat_t;
		logic       lat_s;
		logic       push_wr;
		logic       status_we;
		logic [1:0] status;
		logic       exec;
		logic       div_start;
		logic       div_take;
		logic       wb;
		logic       pop_dec;
		logic       set_comp;
		logic       clr_comp;
		logic       dump_clr;
		logic       dump_rd;
		logic       dump_inc;
		logic       emit;
		logic [1:0] emit_sel;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [3:0] kind;
		logic       cnt_zero;
		logic       cnt_lt2;
		logic       full;
		logic       t_zero;
		logic       div_done;
		logic       dump_last;
	} dps_t;

endpackage

### rtl/core/smwe_div.sv
// Iterative restoring signed divider, one quotient bit per cycle, truncating.
`timescale 1ns / 1ps

module smwe_div
	import smwe_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t num,
	input  word_t den,
	output logic  done,
	output word_t quo
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] step_q;
	word_t             rem_q;
	word_t             quo_q;
	word_t             den_q;
	logic              neg_q;
	logic [WORD_WIDTH:0] shifted;
	logic [WORD_WIDTH:0] diff;

	assign shifted = {rem_q, quo_q[WORD_WIDTH-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == DIV_CW'(WORD_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num[WORD_WIDTH-1] ? (~num + 1'b1) : num;
			den_q <= den[WORD_WIDTH-1] ? (~den + 1'b1) : den;
			neg_q <= num[WORD_WIDTH-1] ^ den[WORD_WIDTH-1];
		end else if (busy_q) begin
			if (!diff[WORD_WIDTH]) begin
				rem_q <= diff[WORD_WIDTH-1:0];
				quo_q <= {quo_q[WORD_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WORD_WIDTH-1:0];
				quo_q <= {quo_q[WORD_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

### rtl/core/smwe_dp.sv
// Datapath: stack memory, depth count, operands, ALU, divider and result forming.
`timescale 1ns / 1ps

module smwe_dp
	import smwe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  req_t request,
	input  cmd_t cmd,
	output dps_t sts,
	output res_t res
);

	word_t             mem [STACK_DEPTH];
	word_t             rd_data_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              rd_en;
	logic [ADDR_W-1:0] wr_addr;
	word_t             wr_data;
	logic              wr_en;

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  cnt_m2;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  dump_n;
	logic              comp_q;
	logic [1:0]        status_q;
	logic [3:0]        kind_q;
	word_t             lit_q;
	word_t             t_q;
	word_t             s_q;
	word_t             r_q;
	word_t             alu;
	word_t             div_quo;
	logic              div_done;
	word_t             emit_val;

	assign cnt_m1 = cnt_q - 1'b1;
	assign cnt_m2 = cnt_q - CNT_W'(2);

	// read port
	always_comb begin
		rd_en   = cmd.rd_top | cmd.rd_second | cmd.dump_rd;
		rd_addr = idx_q[ADDR_W-1:0];
		if (cmd.rd_top)
			rd_addr = cnt_m1[ADDR_W-1:0];
		else if (cmd.rd_second)
			rd_addr = cnt_m2[ADDR_W-1:0];
	end

	// write port: push at the top, or result over the second entry
	always_comb begin
		wr_en   = cmd.push_wr | cmd.wb;
		wr_addr = cmd.push_wr ? cnt_q[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];
		wr_data = cmd.push_wr ? lit_q : r_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			comp_q   <= 1'b0;
			status_q <= ST_OK;
			idx_q    <= '0;
		end else begin
			if (cmd.push_wr)
				cnt_q <= cnt_q + 1'b1;
			else if (cmd.wb || cmd.pop_dec)
				cnt_q <= cnt_m1;
			if (cmd.set_comp)
				comp_q <= 1'b1;
			else if (cmd.clr_comp)
				comp_q <= 1'b0;
			if (cmd.load)
				status_q <= ST_OK;
			else if (cmd.status_we)
				status_q <= cmd.status;
			if (cmd.dump_clr)
				idx_q <= '0;
			else if (cmd.dump_inc)
				idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= request.kind;
			lit_q  <= WORD_WIDTH'(request.literal);
		end
		if (cmd.lat_t)
			t_q <= rd_data_q;
		if (cmd.lat_s)
			s_q <= rd_data_q;
		if (cmd.exec)
			r_q <= alu;
		else if (cmd.div_take)
			r_q <= div_quo;
	end

	always_comb begin
		case (kind_q)
			KIND_ADD: alu = s_q + t_q;
			KIND_SUB: alu = s_q - t_q;
			KIND_MUL: alu = s_q * t_q;
			default:  alu = (s_q == t_q) ? WORD_WIDTH'(1) : '0;
		endcase
	end

	smwe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (s_q),
		.den    (t_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// a dump emits at most MAX_OUT entries
	assign dump_n = (int'(cnt_q) < MAX_OUT) ? cnt_q : CNT_W'(MAX_OUT);

	always_comb begin
		sts.kind      = kind_q;
		sts.cnt_zero  = (cnt_q == '0);
		sts.cnt_lt2   = (cnt_q < CNT_W'(2));
		sts.full      = (cnt_q == CNT_W'(STACK_DEPTH));
		sts.t_zero    = (t_q == '0);
		sts.div_done  = div_done;
		sts.dump_last = ((idx_q + 1'b1) == dump_n);
	end

	always_comb begin
		case (cmd.emit_sel)
			EMIT_TOP:  emit_val = t_q;
			EMIT_DUMP: emit_val = rd_data_q;
			default:   emit_val = '0;
		endcase
		res.value     = 32'(emit_val);
		res.has_value = (cmd.emit_sel != EMIT_NONE);
		res.last      = (cmd.emit_sel != EMIT_DUMP) | sts.dump_last;
		res.status    = status_q;
		res.depth     = 6'(cnt_q);
		res.compiling = comp_q;
	end

endmodule

### rtl/core/smwe_ctrl.sv
// Controller state machine sequencing each word through the datapath.
`timescale 1ns / 1ps

module smwe_ctrl
	import smwe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic out_free,
	input  dps_t sts,
	output logic ready,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_RD_T     = 4'd2;
	localparam logic [3:0] S_RD_S     = 4'd3;
	localparam logic [3:0] S_EXEC     = 4'd4;
	localparam logic [3:0] S_DIV      = 4'd5;
	localparam logic [3:0] S_WB       = 4'd6;
	localparam logic [3:0] S_POP_OUT  = 4'd7;
	localparam logic [3:0] S_DUMP_RD  = 4'd8;
	localparam logic [3:0] S_DUMP_OUT = 4'd9;
	localparam logic [3:0] S_RESULT   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_RESULT;
				unique case (sts.kind) inside
					KIND_PUSH: begin
						if (sts.full) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_OVF;
						end else begin
							cmd.push_wr = 1'b1;
						end
					end
					KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_EQ: begin
						if (sts.cnt_lt2) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_UNF;
						end else begin
							cmd.rd_top = 1'b1;
							state_d    = S_RD_T;
						end
					end
					KIND_POP: begin
						if (sts.cnt_zero) begin
							cmd.status_we = 1'b1;
							cmd.status    = ST_UNF;
						end else begin
							cmd.rd_top = 1'b1;
							state_d    = S_RD_T;
						end
					end
					KIND_DUMP: begin
						if (!sts.cnt_zero) begin
							cmd.dump_clr = 1'b1;
							state_d      = S_DUMP_RD;
						end
					end
					KIND_BEGIN: cmd.set_comp = 1'b1;
					KIND_END:   cmd.clr_comp = 1'b1;
					default: ;
				endcase
			end
			S_RD_T: begin
				cmd.lat_t = 1'b1;
				if (sts.kind == KIND_POP) begin
					cmd.pop_dec = 1'b1;
					state_d     = S_POP_OUT;
				end else begin
					cmd.rd_second = 1'b1;
					state_d       = S_RD_S;
				end
			end
			S_RD_S: begin
				cmd.lat_s = 1'b1;
				state_d   = S_EXEC;
			end
			S_EXEC: begin
				if (sts.kind == KIND_DIV) begin
					if (sts.t_zero) begin
						cmd.status_we = 1'b1;
						cmd.status    = ST_DIVZ;
						state_d       = S_RESULT;
					end else begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end
				end else begin
					cmd.exec = 1'b1;
					state_d  = S_WB;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.div_take = 1'b1;
					state_d      = S_WB;
				end
			end
			S_WB: begin
				cmd.wb  = 1'b1;
				state_d = S_RESULT;
			end
			S_POP_OUT: begin
				cmd.emit_sel = EMIT_TOP;
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_DUMP_RD: begin
				cmd.dump_rd = 1'b1;
				state_d     = S_DUMP_OUT;
			end
			S_DUMP_OUT: begin
				cmd.emit_sel = EMIT_DUMP;
				if (out_free) begin
					cmd.emit = 1'b1;
					if (sts.dump_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.dump_inc = 1'b1;
						state_d      = S_DUMP_RD;
					end
				end
			end
			S_RESULT: begin
				cmd.emit_sel = EMIT_NONE;
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### rtl/core/stack_machine_word_executor_top.sv
// Top level of the stack machine word executor: controller, datapath and output register.
`timescale 1ns / 1ps

// Forth-style data stack engine. One request carries one word (push, add, sub,
// mul, div, equal, pop-and-emit, dump, begin or end definition) and the block
// answers with one or more result items on the result channel.
// Channels: request/result each use valid and stall; a transfer happens on a
// clock edge with valid high and stall low. request_stall is high whenever a
// word is still being worked on, so one word is processed at a time.
// A divide runs on the divider, which retires one quotient bit a cycle and then
// flags done; a dump reads the stack one entry at a time through the single
// read port of the stack memory and emits each entry before reading the next.
// A finished result sits in the result register; the next request is taken
// while it waits, and the engine only stalls when it must emit a further
// result into a still occupied register.
// Reset (arst_n low) empties the stack and clears compile mode; stack memory
// contents are left as they are, entries above the depth are never read.
// While result_stall is high the held result stays unchanged.

module stack_machine_word_executor_top
	import smwe_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic request_valid,
	output logic request_stall,
	input  req_t request,
	output logic result_valid,
	input  logic result_stall,
	output res_t result
);

	cmd_t cmd;
	dps_t sts;
	res_t res;
	logic ready;
	logic out_free;
	logic out_valid_q;
	res_t out_q;

	// output register may be loaded when empty or being drained this cycle
	assign out_free = !out_valid_q || !result_stall;

	smwe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request_valid),
		.out_free  (out_free),
		.sts       (sts),
		.ready     (ready),
		.cmd       (cmd)
	);

	smwe_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (!result_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			out_q <= res;
	end

	assign request_stall = !ready;
	assign result_valid  = out_valid_q;
	assign result        = out_q;

endmodule
